### sv/page_frame_fifo_allocator_unit_macros.svh
// assertion macros for the page frame allocator checker
// no dependencies; included by the checker file only
`ifndef PAGE_FRAME_FIFO_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_FIFO_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pfa_pkg.sv
// shared types and constants for the page frame allocator
// no dependencies; imported by every module of the block
`default_nettype none

package pfa_pkg;

  // fixed field widths
  localparam int FRAME_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int REG_W    = 11;

  localparam int DEF_FRAME_COUNT = 1024;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_USE = 2'd2;

  // configuration register indexes
  localparam logic CFG_RESERVED_FIRST = 1'b0;
  localparam logic CFG_RESERVED_END   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  granted_frame;
    logic [COUNT_W-1:0]  free_count;
  } out_item_t;

  // free ring control for one cycle
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_ctl_t;

  // in-use map control for one cycle
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_bit;
    logic load_done;
  } map_ctl_t;

endpackage

`default_nettype wire

### sv/pfa_ring.sv
// free frame fifo: ring memory with head, tail and fill count
// depends on pfa_pkg
`default_nettype none

module pfa_ring import pfa_pkg::*; #(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ring_ctl_t                           ctl,
  input  logic [$clog2(FRAME_COUNT)-1:0]      push_frame,
  input  logic                                rd_en,
  output logic [$clog2(FRAME_COUNT)-1:0]      rd_frame,
  output logic [$clog2(FRAME_COUNT+1)-1:0]    count
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam logic [AW-1:0] LAST = AW'(FRAME_COUNT - 1);

  logic [AW-1:0] mem [FRAME_COUNT];
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;

  // pointer wrap
  assign head_next = (head == LAST) ? '0 : head + AW'(1);
  assign tail_next = (tail == LAST) ? '0 : tail + AW'(1);

  // memory write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= push_frame;
    end
    if (rd_en) begin
      rd_frame <= mem[head];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      tail  <= tail_next;
      count <= count + CW'(1);
    end else if (ctl.pop) begin
      head  <= head_next;
      count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

### sv/pfa_use_map.sv
// frame in-use bitmap in a one-port-write, one-port-read memory
// depends on pfa_pkg; reads as all clear until the first init walk completes
`default_nettype none

module pfa_use_map import pfa_pkg::*; #(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  map_ctl_t                       ctl,
  input  logic [$clog2(FRAME_COUNT)-1:0] rd_addr,
  input  logic [$clog2(FRAME_COUNT)-1:0] wr_addr,
  output logic                           rd_bit
);

  logic mem [FRAME_COUNT];
  logic rd_q;
  logic rd_loaded;
  logic loaded;

  // memory access
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= ctl.wr_bit;
    end
    if (ctl.rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_loaded <= loaded;
    end
  end

  // epoch flag: contents count only after a full init walk
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
    end else if (ctl.load_done) begin
      loaded <= 1'b1;
    end
  end

  assign rd_bit = rd_q & rd_loaded;

endmodule

`default_nettype wire

### sv/page_frame_fifo_allocator_unit.sv
// Flow: allocate, free and an unused kind enter their own state, where the
// result is registered once the result slot is free; init writes one frame
// per cycle over all frames, holding on the last until the result slot is free.
// Throughput: one transaction at a time, a registered read then a write-back.
// Reset: control, pointers and configuration clear at once; the in-use map reads
// as all clear through an epoch flag, so there is no clearing pass.
`default_nettype none

module page_frame_fifo_allocator_unit import pfa_pkg::*; #(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  localparam int AW = $clog2(FRAME_COUNT);
  localparam int CW = $clog2(FRAME_COUNT + 1);
  localparam logic [AW-1:0] LAST = AW'(FRAME_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ALLOC,
    S_FREE,
    S_SKIP
  } state_t;

  state_t state;
  state_t state_next;

  logic [REG_W-1:0]   res_first;
  logic [REG_W-1:0]   res_end;
  logic [FRAME_W-1:0] frame_q;
  logic [AW-1:0]      walk_idx;

  ring_ctl_t ring_ctl;
  map_ctl_t  map_ctl;
  logic [AW-1:0] push_frame;
  logic [AW-1:0] map_wr_addr;
  logic [AW-1:0] ring_frame;
  logic [CW-1:0] count;
  logic          map_bit;

  logic      accept;
  logic      slot_free;
  logic      res_fire;
  out_item_t res;
  logic      walk_last;
  logic      walk_go;
  logic      reserved;
  logic      not_full;
  logic      bad_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign not_full  = (count != CW'(FRAME_COUNT));

  assign walk_last = (walk_idx == LAST);
  assign walk_go   = !walk_last || slot_free;
  assign reserved  = (32'(walk_idx) >= 32'(res_first)) && (32'(walk_idx) < 32'(res_end));
  assign bad_free  = (32'(frame_q) >= FRAME_COUNT) || !map_bit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      res_first <= '0;
      res_end   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESERVED_FIRST: res_first <= cfg_data;
        CFG_RESERVED_END:   res_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // memory control and result per state
  always_comb begin
    ring_ctl       = '0;
    map_ctl        = '0;
    push_frame     = walk_idx;
    map_wr_addr    = walk_idx;
    res_fire       = 1'b0;
    res.status     = ST_OK;
    res.granted_frame = '0;
    res.free_count = COUNT_W'(count);
    state_next     = state;

    map_ctl.rd_en  = accept;
    ring_ctl.clear = accept && (in_data.kind == KIND_INIT);

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            KIND_INIT:  state_next = S_INIT;
            KIND_ALLOC: state_next = S_ALLOC;
            KIND_FREE:  state_next = S_FREE;
            default:    state_next = S_SKIP;
          endcase
        end
      end
      S_INIT: begin
        if (walk_go) begin
          map_ctl.wr_en  = 1'b1;
          map_ctl.wr_bit = reserved;
          ring_ctl.push  = !reserved && not_full;
          if (walk_last) begin
            map_ctl.load_done = 1'b1;
            res_fire       = 1'b1;
            res.free_count = COUNT_W'(count + CW'(ring_ctl.push));
            state_next     = S_IDLE;
          end
        end
      end
      S_ALLOC: begin
        if (slot_free) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
          if (count == '0) begin
            res.status = ST_EMPTY;
          end else begin
            ring_ctl.pop   = 1'b1;
            map_ctl.wr_en  = 1'b1;
            map_ctl.wr_bit = 1'b1;
            map_wr_addr    = ring_frame;
            res.granted_frame = FRAME_W'(ring_frame);
            res.free_count = COUNT_W'(count - CW'(1));
          end
        end
      end
      S_FREE: begin
        if (slot_free) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
          if (bad_free) begin
            res.status = ST_NOT_IN_USE;
          end else begin
            map_ctl.wr_en  = 1'b1;
            map_ctl.wr_bit = 1'b0;
            map_wr_addr    = AW'(frame_q);
            ring_ctl.push  = not_full;
            push_frame     = AW'(frame_q);
            res.free_count = COUNT_W'(count + CW'(not_full));
          end
        end
      end
      S_SKIP: begin
        if (slot_free) begin
          res_fire   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, held item and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (res_fire) begin
      out_data <= res;
    end
    if (accept) begin
      frame_q  <= in_data.frame;
      walk_idx <= '0;
    end else if (state == S_INIT && walk_go) begin
      walk_idx <= walk_idx + AW'(1);
    end
  end

  // free frame fifo
  pfa_ring #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ring_ctl),
    .push_frame (push_frame),
    .rd_en      (accept),
    .rd_frame   (ring_frame),
    .count      (count)
  );

  // in-use bitmap
  pfa_use_map #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (map_ctl),
    .rd_addr (AW'(in_data.frame)),
    .wr_addr (map_wr_addr),
    .rd_bit  (map_bit)
  );

endmodule

`default_nettype wire

### sv/pfa_checker.sv
// port-level checks for the page frame allocator, bound to the top level
// depends on pfa_pkg and page_frame_fifo_allocator_unit_macros.svh
`default_nettype none
`include "page_frame_fifo_allocator_unit_macros.svh"

module pfa_checker import pfa_pkg::*; #(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic in_fire;
  logic out_stall;
  logic out_empty;
  logic empty_clean;
  logic count_ok;

  assign in_fire     = in_valid && in_ready;
  assign out_stall   = out_valid && !out_ready;
  assign out_empty   = out_valid && (out_data.status == ST_EMPTY);
  assign empty_clean = (out_data.free_count == '0) && (out_data.granted_frame == '0);
  assign count_ok    = (32'(out_data.free_count) <= FRAME_COUNT);

  // a stalled result stays valid and holds its payload
  `PFA_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid, "stalled result dropped")
  `PFA_ASSERT_NEXT(a_data_hold, clk, rst, out_stall, $stable(out_data), "stalled result changed")

  // one transaction in flight: never two accepts in a row
  `PFA_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_fire, !in_ready, "input accepted twice in a row")

  // an empty answer means an empty list and no grant
  `PFA_ASSERT_NOW(a_empty, clk, rst, out_empty, empty_clean, "empty answer with frames left")

  // free count never exceeds the frame total
  `PFA_ASSERT_NOW(a_count_range, clk, rst, out_valid, count_ok, "free count out of range")

endmodule

bind page_frame_fifo_allocator_unit pfa_checker #(.FRAME_COUNT(FRAME_COUNT)) u_pfa_checker (.*);

`default_nettype wire

### bench/page_frame_fifo_allocator_unit_checker.sv
// result checker for the page frame allocator: watches both channels and the config port
// keeps its own free ring and in-use map and compares every result in order
// depends on pfa_pkg for the payload structs, codes and widths
`timescale 1ns / 100ps

module page_frame_fifo_allocator_unit_checker import pfa_pkg::*; #(
  parameter int FRAME_COUNT = DEF_FRAME_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output int               fault_count,
  output int               outstanding
);

  // shadow allocator state
  logic [FRAME_W-1:0] ring_frames [FRAME_COUNT];
  logic [FRAME_W-1:0] ring_head;
  logic [FRAME_W-1:0] ring_tail;
  logic [COUNT_W-1:0] ring_count;
  bit                 frame_busy [FRAME_COUNT];
  logic [REG_W-1:0]   kernel_first;
  logic [REG_W-1:0]   kernel_end;

  out_item_t awaited_results [$];
  int        faults = 0;

  function automatic logic [FRAME_W-1:0] ring_advance(logic [FRAME_W-1:0] pos);
    return (int'(pos) == FRAME_COUNT - 1) ? '0 : pos + 1'b1;
  endfunction

  function automatic void ring_append(logic [FRAME_W-1:0] f);
    if (int'(ring_count) < FRAME_COUNT) begin
      ring_frames[ring_tail] = f;
      ring_tail = ring_advance(ring_tail);
      ring_count = ring_count + 1'b1;
    end
  endfunction

  // apply one transaction to the shadow state and return its result
  function automatic out_item_t allocator_step(in_item_t item);
    out_item_t res;
    logic [FRAME_W-1:0] f;
    res.status = ST_OK;
    res.granted_frame = '0;
    case (item.kind)
      KIND_INIT: begin
        ring_head = '0;
        ring_tail = '0;
        ring_count = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
          if (i >= int'(kernel_first) && i < int'(kernel_end)) begin
            frame_busy[i] = 1'b1;
          end else begin
            frame_busy[i] = 1'b0;
            ring_append(FRAME_W'(i));
          end
        end
      end
      KIND_ALLOC: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          f = ring_frames[ring_head];
          ring_head = ring_advance(ring_head);
          ring_count = ring_count - 1'b1;
          frame_busy[f] = 1'b1;
          res.granted_frame = f;
        end
      end
      KIND_FREE: begin
        if (int'(item.frame) >= FRAME_COUNT || !frame_busy[item.frame]) begin
          res.status = ST_NOT_IN_USE;
        end else begin
          frame_busy[item.frame] = 1'b0;
          ring_append(item.frame);
        end
      end
      default: ;
    endcase
    res.free_count = ring_count;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst) begin
      ring_head = '0;
      ring_tail = '0;
      ring_count = '0;
      kernel_first = '0;
      kernel_end = '0;
      foreach (frame_busy[i]) frame_busy[i] = 1'b0;
      awaited_results.delete();
    end else begin
      // result transaction: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (faults < 10)
            $display("[%0t] unexpected result: status %0d granted %0d count %0d",
                     $realtime, out_data.status, out_data.granted_frame, out_data.free_count);
          faults++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_data.status !== exp_res.status ||
              out_data.granted_frame !== exp_res.granted_frame ||
              out_data.free_count !== exp_res.free_count) begin
            if (faults < 10)
              $display("[%0t] mismatch: expected status %0d granted %0d count %0d, got %0d %0d %0d",
                       $realtime, exp_res.status, exp_res.granted_frame, exp_res.free_count,
                       out_data.status, out_data.granted_frame, out_data.free_count);
            faults++;
          end
        end
      end
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_RESERVED_FIRST) kernel_first = cfg_data;
        else kernel_end = cfg_data;
      end
      // input transaction: predict its result
      if (in_valid && in_ready)
        awaited_results.push_back(allocator_step(in_data));
    end
    fault_count <= faults;
    outstanding <= awaited_results.size();
  end

endmodule

### bench/tb_page_frame_fifo_allocator_unit.sv
// top of the page frame allocator bench: clock, reset, stimulus and the verdict
// instantiates page_frame_fifo_allocator_unit and page_frame_fifo_allocator_unit_checker
// depends on pfa_pkg for payload types and codes
`timescale 1ns / 100ps

module tb_page_frame_fifo_allocator_unit;
  import pfa_pkg::*;

  localparam int FRAME_COUNT = DEF_FRAME_COUNT;
  localparam int STALL_LIMIT = 20000;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_RESERVED_FIRST;
  logic [REG_W-1:0] cfg_data = '0;

  int fault_count;
  int outstanding;
  int gap_pct = 12;
  int ready_gap_pct = 12;
  int stall_cycles = 0;

  // frames handed out and not yet given back, used to build legal frees
  logic [FRAME_W-1:0] held_frames [$];
  logic [KIND_W-1:0]  sent_kinds [$];
  logic [FRAME_W-1:0] last_freed = '0;

  page_frame_fifo_allocator_unit #(.FRAME_COUNT(FRAME_COUNT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  page_frame_fifo_allocator_unit_checker #(.FRAME_COUNT(FRAME_COUNT)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fault_count(fault_count), .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ready_gap_pct);
  end

  // collect granted frames so later frees hit frames in use
  always @(posedge clk) begin
    logic [KIND_W-1:0] k;
    if (!rst && out_valid && out_ready && sent_kinds.size() > 0) begin
      k = sent_kinds.pop_front();
      if (k == KIND_ALLOC && out_data.status == ST_OK)
        held_frames.push_back(out_data.granted_frame);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one input transaction, with an optional random gap ahead of it
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [FRAME_W-1:0] frame);
    in_item_t item;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 50) @(posedge clk);
    end
    item.kind = kind;
    item.frame = frame;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_kinds.push_back(kind);
    if (kind == KIND_INIT) held_frames.delete();
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_range(input logic [REG_W-1:0] lo_frame, input logic [REG_W-1:0] hi_frame);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_RESERVED_FIRST;
    cfg_data <= lo_frame;
    @(posedge clk);
    cfg_index <= CFG_RESERVED_END;
    cfg_data <= hi_frame;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // init under a new kernel range, then a mix of allocs, legal frees and noise
  task automatic run_phase(input logic [REG_W-1:0] lo_frame, input logic [REG_W-1:0] hi_frame,
                           input int items, input int alloc_pct, input bit allow_init,
                           input bit quiet);
    int roll;
    int idx;
    logic [FRAME_W-1:0] fr;
    set_range(lo_frame, hi_frame);
    gap_pct = quiet ? 0 : 12;
    ready_gap_pct = quiet ? 0 : 12;
    send_item(KIND_INIT, FRAME_W'($urandom_range(FRAME_COUNT - 1)));
    repeat (items) begin
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
        send_item(KIND_ALLOC, FRAME_W'($urandom_range(FRAME_COUNT - 1)));
      end else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
        if (held_frames.size() > 0) begin
          idx = $urandom_range(held_frames.size() - 1);
          fr = held_frames[idx];
          held_frames.delete(idx);
        end else begin
          fr = FRAME_W'($urandom_range(FRAME_COUNT - 1));
        end
        last_freed = fr;
        send_item(KIND_FREE, fr);
      end else begin
        case ($urandom_range(3))
          0: send_item(allow_init ? KIND_INIT : KIND_UNUSED,
                       FRAME_W'($urandom_range(FRAME_COUNT - 1)));
          1: send_item(KIND_UNUSED, FRAME_W'($urandom_range(FRAME_COUNT - 1)));
          2: send_item(KIND_FREE, FRAME_W'($urandom_range(FRAME_COUNT - 1)));
          default: send_item(KIND_FREE, last_freed);
        endcase
      end
    end
  endtask

  initial begin
    logic [REG_W-1:0] rand_lo;
    logic [REG_W-1:0] rand_hi;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any init: empty list, free of an unused frame, unused kind
    send_item(KIND_ALLOC, 10'h000);
    send_item(KIND_FREE, 10'd5);
    send_item(KIND_UNUSED, 10'h3FF);

    // small kernel range: in-order grants, reserved frame freed, double free
    set_range(11'd2, 11'd5);
    send_item(KIND_INIT, 10'h2AA);
    send_item(KIND_ALLOC, 10'h155);
    send_item(KIND_ALLOC, 10'h000);
    send_item(KIND_ALLOC, 10'h3FF);
    send_item(KIND_FREE, 10'd3);
    send_item(KIND_FREE, 10'd3);
    send_item(KIND_FREE, 10'd1);
    send_item(KIND_FREE, 10'h3FF);
    send_item(KIND_FREE, 10'h000);
    send_item(KIND_UNUSED, 10'h155);
    send_item(KIND_ALLOC, 10'h2AA);

    // everything reserved: list starts empty, frees of top and bottom frames
    set_range(11'd0, 11'd1024);
    send_item(KIND_INIT, 10'h000);
    send_item(KIND_ALLOC, 10'h000);
    send_item(KIND_FREE, 10'h3FF);
    send_item(KIND_ALLOC, 10'h000);
    send_item(KIND_FREE, 10'h000);
    send_item(KIND_FREE, 10'h2AA);
    send_item(KIND_ALLOC, 10'h000);
    send_item(KIND_ALLOC, 10'h000);

    // nothing reserved and no re-init, so head and tail both wrap
    run_phase(11'd0, 11'd0, 1200, 90, 1'b0, 1'b0);
    // eight free frames with no idling on either side
    run_phase(11'd2, 11'd1018, 150, 50, 1'b1, 1'b1);
    // inverted range reserves nothing
    run_phase(11'd700, 11'd300, 50, 45, 1'b1, 1'b0);
    run_phase(11'd0, 11'd1024, 50, 40, 1'b1, 1'b0);
    run_phase(11'd1, 11'd1023, 50, 55, 1'b1, 1'b0);
    run_phase(11'd1024, 11'd1024, 50, 50, 1'b1, 1'b0);
    run_phase(11'd1023, 11'd1024, 50, 50, 1'b1, 1'b0);
    rand_lo = REG_W'($urandom_range(1024));
    rand_hi = REG_W'($urandom_range(1024));
    run_phase(rand_lo, rand_hi, 50, 50, 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fault_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
